[rtl/core/mrp_pkg.sv]
package mrp_pkg;

    localparam int unsigned SLOT_W = 5;
    localparam int unsigned LOG_W  = 5;

    localparam logic [LOG_W-1:0] LOG_MIN = 5'd5;
    localparam logic [LOG_W-1:0] LOG_MAX = 5'd31;

    localparam logic [31:0] BASE_VALID  = 32'h0000_0010;
    localparam logic [31:0] ATTR_ENABLE = 32'h0000_0001;
    localparam logic [31:0] ATTR_XN     = 32'h1000_0000;
    localparam logic [31:0] ATTR_AP_RW  = 32'h0300_0000;
    localparam logic [31:0] ATTR_AP_RO  = 32'h0600_0000;
    localparam logic [31:0] ATTR_NORMAL = 32'h000F_0000;
    localparam logic [31:0] ATTR_DEVICE = 32'h0005_0000;

    typedef struct packed {
        logic        has_descriptor;
        logic        is_stack;
        logic [31:0] region_base;
        logic [31:0] region_size;
        logic        perm_write;
        logic        perm_exec;
        logic        device_memory;
        logic        kernel_space;
        logic        last_descriptor;
    } t_desc;

    typedef struct packed {
        logic              write_valid;
        logic [3:0]        slot_number;
        logic [31:0]       base_word;
        logic [31:0]       attr_word;
        logic [SLOT_W-1:0] programmed_count;
        logic              run_last;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_WRITE,
        ST_CLOSE
    } t_state;

    typedef struct packed {
        logic load;
        logic search_step;
        logic emit_write;
        logic emit_disable;
        logic emit_marker;
        logic slot_adv;
        logic fill_step;
        logic space_end;
    } t_cmd;

    typedef struct packed {
        logic take;
        logic size_zero;
        logic last;
        logic hit;
        logic out_free;
        logic fill_done;
        logic write_ends;
        logic fill_ends;
    } t_sts;

endpackage

[rtl/core/mrp_if.sv]
interface mrp_desc_if;
    import mrp_pkg::*;

    logic  valid;
    logic  ready;
    t_desc payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mrp_wr_if;
    import mrp_pkg::*;

    logic valid;
    logic ready;
    t_wr  payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/mrp_ctrl.sv]
module mrp_ctrl
    import mrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.take) begin
                    n_state = i_sts.size_zero ? ST_WRITE : ST_SEARCH;
                end else if (i_sts.last) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (i_sts.hit) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            ST_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_write = 1'b1;
                    o_cmd.slot_adv   = 1'b1;
                    if (!i_sts.last) begin
                        n_state = ST_IDLE;
                    end else if (i_sts.write_ends) begin
                        o_cmd.space_end = 1'b1;
                        n_state         = ST_IDLE;
                    end else begin
                        n_state = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (i_sts.out_free) begin
                    if (i_sts.fill_done) begin
                        o_cmd.emit_marker = 1'b1;
                        o_cmd.space_end   = 1'b1;
                        n_state           = ST_IDLE;
                    end else begin
                        o_cmd.emit_disable = 1'b1;
                        o_cmd.fill_step    = 1'b1;
                        if (i_sts.fill_ends) begin
                            o_cmd.space_end = 1'b1;
                            n_state         = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/mrp_dp.sv]
module mrp_dp
    import mrp_pkg::*;
#(
    parameter int NUM_REGIONS     = 8,
    parameter int FIRST_USER_SLOT = 3
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_desc i_desc,
    input  t_cmd  i_cmd,
    output t_sts  o_sts,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_wr   o_out
);

    localparam logic [SLOT_W-1:0] NUM_SLOTS  = SLOT_W'(NUM_REGIONS);
    localparam logic [SLOT_W-1:0] FIRST_SLOT = SLOT_W'(FIRST_USER_SLOT);

    t_desc             r_desc;
    logic [31:0]       r_end;
    logic [LOG_W-1:0]  r_l;
    logic [SLOT_W-1:0] r_next_slot;
    logic [SLOT_W-1:0] r_fill;
    logic              r_out_valid;
    t_wr               r_out;

    logic [31:0]       rsize;
    logic [31:0]       rbase;
    logic [31:0]       rtop;
    logic [SLOT_W-1:0] slot_inc;
    logic [SLOT_W-1:0] fill_inc;
    logic [31:0]       attr;
    logic              out_free;

    function automatic logic [SLOT_W-1:0] used_count(input logic [SLOT_W-1:0] slot);
        return (slot <= FIRST_SLOT) ? '0 : slot - FIRST_SLOT;
    endfunction

    assign rsize    = 32'd1 << r_l;
    assign rbase    = r_desc.region_base & ~(rsize - 32'd1);
    assign rtop     = rbase + rsize;
    assign slot_inc = r_next_slot + SLOT_W'(1);
    assign fill_inc = r_fill + SLOT_W'(1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        attr = r_desc.perm_write ? ATTR_AP_RW : ATTR_AP_RO;
        if (!r_desc.perm_exec) begin
            attr = attr | ATTR_XN;
        end
        attr = attr | (r_desc.device_memory ? ATTR_DEVICE : ATTR_NORMAL);
    end

    always_comb begin
        o_sts.take       = r_desc.has_descriptor && !r_desc.is_stack
                           && !r_desc.kernel_space && (r_next_slot < NUM_SLOTS);
        o_sts.size_zero  = (r_desc.region_size == 32'd0);
        o_sts.last       = r_desc.last_descriptor;
        o_sts.hit        = (rtop >= r_end) || (r_l >= LOG_MAX);
        o_sts.out_free   = out_free;
        o_sts.fill_done  = (r_fill >= NUM_SLOTS);
        o_sts.write_ends = (slot_inc >= NUM_SLOTS);
        o_sts.fill_ends  = (fill_inc >= NUM_SLOTS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_desc <= i_desc;
            r_end  <= i_desc.region_base + i_desc.region_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l <= LOG_MIN;
        end else if (i_cmd.load) begin
            r_l <= LOG_MIN;
        end else if (i_cmd.search_step) begin
            r_l <= r_l + LOG_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= FIRST_SLOT;
            r_fill      <= FIRST_SLOT;
        end else if (i_cmd.space_end) begin
            r_next_slot <= FIRST_SLOT;
            r_fill      <= FIRST_SLOT;
        end else if (i_cmd.slot_adv) begin
            r_next_slot <= slot_inc;
            r_fill      <= slot_inc;
        end else if (i_cmd.fill_step) begin
            r_fill <= fill_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_write || i_cmd.emit_disable || i_cmd.emit_marker) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_write) begin
            r_out.write_valid      <= 1'b1;
            r_out.slot_number      <= r_next_slot[3:0];
            r_out.programmed_count <= used_count(slot_inc);
            r_out.run_last         <= r_desc.last_descriptor && (slot_inc >= NUM_SLOTS);
            if (r_desc.region_size == 32'd0) begin
                r_out.base_word <= '0;
                r_out.attr_word <= '0;
            end else begin
                r_out.base_word <= rbase | BASE_VALID | {28'd0, r_next_slot[3:0]};
                r_out.attr_word <= ATTR_ENABLE | attr
                                   | {26'd0, r_l - LOG_W'(1), 1'b0};
            end
        end else if (i_cmd.emit_disable) begin
            r_out.write_valid      <= 1'b1;
            r_out.slot_number      <= r_fill[3:0];
            r_out.base_word        <= '0;
            r_out.attr_word        <= '0;
            r_out.programmed_count <= used_count(r_next_slot);
            r_out.run_last         <= (fill_inc >= NUM_SLOTS);
        end else if (i_cmd.emit_marker) begin
            r_out.write_valid      <= 1'b0;
            r_out.slot_number      <= '0;
            r_out.base_word        <= '0;
            r_out.attr_word        <= '0;
            r_out.programmed_count <= used_count(r_next_slot);
            r_out.run_last         <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    a_log_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_l >= LOG_MIN) && (r_l <= LOG_MAX))
        else $error("size exponent out of range");

    a_fill_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill >= r_next_slot)
        else $error("fill pointer behind next slot");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_write || i_cmd.emit_disable || i_cmd.emit_marker) |-> out_free)
        else $error("result overwrites a pending transaction");
`endif

endmodule

[rtl/core/mpu_region_programmer_top.sv]
// Channel   Dir  Modport  Payload
// i_desc    in   sink     t_desc: one region descriptor per transaction
// o_wr      out  source   t_wr:   one slot write or end marker per transaction
//
// A descriptor is loaded in the idle state and classified in the check state, then
// tries sizes from 32 bytes to 2^31 (up to 27) in the search loop, then is written.
// A closing descriptor adds a disable write per remaining slot, else the end marker.
// Reset is synchronous; the slot pointer returns to the first user slot.
// The output register stalls the sequencer only while a transaction waits in it.
module mpu_region_programmer_top
    import mrp_pkg::*;
#(
    parameter int NUM_REGIONS     = 8,
    parameter int FIRST_USER_SLOT = 3
) (
    input logic      i_clk,
    input logic      i_rst_n,
    mrp_desc_if.sink i_desc,
    mrp_wr_if.source o_wr
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;
    t_wr  out_wr;

    mrp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_desc.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrp_dp #(
        .NUM_REGIONS     (NUM_REGIONS),
        .FIRST_USER_SLOT (FIRST_USER_SLOT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (i_desc.payload),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (out_valid),
        .i_out_ready (o_wr.ready),
        .o_out       (out_wr)
    );

    assign i_desc.ready = in_ready;
    assign o_wr.valid   = out_valid;
    assign o_wr.payload = out_wr;

endmodule
